### hdl/rss_pkg.sv
// shared types, widths and codes of the ramp/soak setpoint sequencer
package rss_pkg;

	// table and field widths
	localparam int MAX_STEPS = 32;
	localparam int STEP_W    = $clog2(MAX_STEPS);
	localparam int CFG_W     = 6;
	localparam int DUR_W     = 24;
	localparam int TGT_W     = 16;
	localparam int IN_W      = 96;
	localparam int OUT_W     = 40;

	// command codes carried on s_tuser
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	// status codes carried on m_tuser
	localparam logic [1:0] ST_APPLIED  = 2'd0;
	localparam logic [1:0] ST_DONE     = 2'd1;
	localparam logic [1:0] ST_STOPPED  = 2'd2;
	localparam logic [1:0] ST_NO_STEPS = 2'd3;

	// one profile table entry
	typedef struct packed {
		logic [DUR_W-1:0]        dur;
		logic                    temp_en;
		logic signed [TGT_W-1:0] temp_from;
		logic signed [TGT_W-1:0] temp_to;
		logic                    hum_en;
		logic signed [TGT_W-1:0] hum_from;
		logic signed [TGT_W-1:0] hum_to;
	} step_t;

	// request to the interpolation unit
	typedef struct packed {
		logic                    start;
		logic signed [TGT_W-1:0] tgt_from;
		logic signed [TGT_W-1:0] tgt_to;
		logic [DUR_W-1:0]        dur;
		logic [DUR_W-1:0]        off;
	} interp_req_t;

endpackage

### hdl/rss_interp.sv
// linear interpolation unit: one multiply then a bit-serial restoring divide
module rss_interp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rss_pkg::interp_req_t            req,
	output logic                            done,
	output logic signed [rss_pkg::TGT_W-1:0] result
);
	import rss_pkg::*;

	localparam int MAG_W  = TGT_W;
	localparam int PROD_W = MAG_W + DUR_W;
	localparam int CNT_W  = $clog2(MAG_W);

	localparam logic [1:0] I_IDLE = 2'd0;
	localparam logic [1:0] I_MUL  = 2'd1;
	localparam logic [1:0] I_DIV  = 2'd2;
	localparam logic [1:0] I_FIN  = 2'd3;

	logic [1:0]              state_q;
	logic [DUR_W-1:0]        d_q;
	logic [DUR_W-1:0]        off_q;
	logic [MAG_W-1:0]        mag_q;
	logic                    neg_q;
	logic                    short_q;
	logic signed [TGT_W-1:0] from_q;
	logic signed [TGT_W-1:0] to_q;
	logic [DUR_W:0]          rem_q;
	logic [MAG_W-1:0]        quo_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic signed [TGT_W-1:0] result_q;

	logic [DUR_W-1:0]        d_full;
	logic [DUR_W-1:0]        off_clamp;
	logic signed [TGT_W:0]   delta;
	logic [TGT_W:0]          delta_abs;
	logic [PROD_W-1:0]       prod;
	logic [DUR_W:0]          trial;
	logic                    trial_ge;
	logic signed [TGT_W+1:0] from_ext;
	logic signed [TGT_W+1:0] quo_ext;
	logic signed [TGT_W+1:0] w_raw;
	logic signed [TGT_W+1:0] w_adj;

	// setup: divisor, clamped offset and magnitude of the swing
	always_comb begin
		d_full    = req.dur - DUR_W'(1);
		off_clamp = (req.off > d_full) ? d_full : req.off;
		delta     = (TGT_W+1)'(req.tgt_to) - (TGT_W+1)'(req.tgt_from);
		delta_abs = delta[TGT_W] ? (TGT_W+1)'(-delta) : delta;
	end

	// product of magnitude and offset, registered into the divider
	assign prod = PROD_W'(mag_q) * PROD_W'(off_q);

	// one restoring divide step
	assign trial    = {rem_q[DUR_W-1:0], quo_q[MAG_W-1]};
	assign trial_ge = (trial >= {1'b0, d_q});

	// add the quotient and round the exact value toward zero
	always_comb begin
		from_ext = (TGT_W+2)'(from_q);
		quo_ext  = signed'({2'b00, quo_q});
		w_raw    = neg_q ? (from_ext - quo_ext) : (from_ext + quo_ext);
		w_adj    = w_raw;
		if (rem_q != '0) begin
			if (!neg_q && w_raw < 0) begin
				w_adj = w_raw + (TGT_W+2)'(1);
			end else if (neg_q && w_raw > 0) begin
				w_adj = w_raw - (TGT_W+2)'(1);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= I_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				I_IDLE: begin
					if (req.start) begin
						state_q <= (req.dur <= DUR_W'(1)) ? I_FIN : I_MUL;
					end
				end
				I_MUL: begin
					cnt_q   <= '0;
					state_q <= I_DIV;
				end
				I_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MAG_W - 1)) begin
						state_q <= I_FIN;
					end
				end
				I_FIN: begin
					done_q  <= 1'b1;
					state_q <= I_IDLE;
				end
				default: state_q <= I_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			I_IDLE: begin
				if (req.start) begin
					d_q     <= d_full;
					off_q   <= off_clamp;
					mag_q   <= delta_abs[MAG_W-1:0];
					neg_q   <= delta[TGT_W];
					short_q <= (req.dur <= DUR_W'(1));
					from_q  <= req.tgt_from;
					to_q    <= req.tgt_to;
				end
			end
			I_MUL: begin
				rem_q <= {1'b0, prod[PROD_W-1:MAG_W]};
				quo_q <= prod[MAG_W-1:0];
			end
			I_DIV: begin
				rem_q <= trial_ge ? (trial - {1'b0, d_q}) : trial;
				quo_q <= {quo_q[MAG_W-2:0], trial_ge};
			end
			I_FIN: begin
				result_q <= short_q ? to_q : w_adj[TGT_W-1:0];
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### hdl/ramp_soak_setpoint_sequencer_core.sv
// top level of the ramp/soak setpoint sequencer
//
// Commands enter on the s_ stream: s_tuser holds the command (write step,
// start, stop, tick), s_tdata the step fields. A write step loads one entry
// of the 32-entry profile table and gives no word; a start, stop or tick
// may give one result word on the m_ stream, m_tuser holding the status.
// steps_in_use is to be written through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce it. One command is in work at a
// time and s_tready is low meanwhile; it rises again in the same cycle as the
// result word is registered. A stop, or a tick finding the run over, goes
// straight to its word; a tick ending the last step gives it after the table
// read. A start, or a tick that applies targets, reads the entry (the next
// one too when the tick moves on) and works each enabled channel in turn, a
// one-tick step skipping the multiply and divide; the two channels share one
// interpolation unit (one 16x24 multiply and a 16-step serial divide).
// The result sits in an output register: if the receiver stalls, the next
// command is still taken and worked on, and only its delivery waits.
// Reset clears the run state and the step count; table entries hold no
// value until written and must be written before a run reads them.
module ramp_soak_setpoint_sequencer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// step_index, duration_ticks, temp_enable, temp_begin, temp_finish,
	// hum_enable, hum_begin, hum_finish, restore_on_stop
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rss_pkg::IN_W-1:0]       s_tdata,
	// command
	input  logic [1:0]                     s_tuser,
	// current_step, temp_valid, target_temp, hum_valid, target_hum,
	// restore_request
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rss_pkg::OUT_W-1:0]      m_tdata,
	// status
	output logic [1:0]                     m_tuser,
	input  logic                           cfg_we,
	input  logic [rss_pkg::CFG_W-1:0]      cfg_wdata
);
	import rss_pkg::*;

	typedef struct packed {
		logic                    restore;
		logic signed [TGT_W-1:0] hum;
		logic                    hum_valid;
		logic signed [TGT_W-1:0] temp;
		logic                    temp_valid;
		logic [STEP_W-1:0]       step;
	} res_data_t;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_TCHK = 3'd3;
	localparam logic [2:0] S_CH   = 3'd4;
	localparam logic [2:0] S_CHW  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]        state_q;
	logic [CFG_W-1:0]  steps_q;
	logic [STEP_W-1:0] pos_q;
	logic [DUR_W-1:0]  off_q;
	logic              running_q;
	logic              ch_q;
	logic [1:0]        cmd_q;
	logic [IN_W-1:0]   in_q;
	step_t             mem [MAX_STEPS];
	step_t             rd_q;
	logic [1:0]        res_status_q;
	res_data_t         res_q;
	logic              m_tvalid_q;
	logic [1:0]        out_status_q;
	res_data_t         out_q;

	logic [CFG_W-1:0]  n;
	logic [STEP_W-1:0] n_last;
	logic [CFG_W-1:0]  pos_next;
	logic              accept;
	logic              out_free;
	step_t             wr_entry;
	logic [STEP_W-1:0] wr_idx;
	logic              ch_en;
	interp_req_t       req;
	logic              ip_done;
	logic signed [TGT_W-1:0] ip_result;

	// step count and position arithmetic
	always_comb begin
		n        = (steps_q > CFG_W'(MAX_STEPS)) ? CFG_W'(MAX_STEPS) : steps_q;
		n_last   = (n == '0) ? '0 : STEP_W'(n - CFG_W'(1));
		pos_next = CFG_W'(pos_q) + CFG_W'(1);
	end

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// unpack the latched command word
	assign wr_idx            = in_q[4:0];
	assign wr_entry.dur      = (in_q[28:5] == '0) ? DUR_W'(1) : in_q[28:5];
	assign wr_entry.temp_en  = in_q[29];
	assign wr_entry.temp_from = in_q[45:30];
	assign wr_entry.temp_to  = in_q[61:46];
	assign wr_entry.hum_en   = in_q[62];
	assign wr_entry.hum_from = in_q[78:63];
	assign wr_entry.hum_to   = in_q[94:79];

	// interpolation request for the channel in work
	always_comb begin
		ch_en        = ch_q ? rd_q.hum_en : rd_q.temp_en;
		req.start    = (state_q == S_CH) && ch_en;
		req.tgt_from = ch_q ? rd_q.hum_from : rd_q.temp_from;
		req.tgt_to   = ch_q ? rd_q.hum_to : rd_q.temp_to;
		req.dur      = rd_q.dur;
		req.off      = off_q;
	end

	rss_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (ip_done),
		.result (ip_result)
	);

	// profile table, written on write step, read at the current position
	always_ff @(posedge clk) begin
		if (state_q == S_DEC && cmd_q == CMD_WRITE) begin
			mem[wr_idx] <= wr_entry;
		end
		rd_q <= mem[pos_q];
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			steps_q    <= '0;
			pos_q      <= '0;
			off_q      <= '0;
			running_q  <= 1'b0;
			ch_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				steps_q <= cfg_wdata;
			end
			// a word taken while a new one is loaded is replaced in S_OUT
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					case (cmd_q)
						CMD_WRITE: begin
							running_q <= 1'b0;
							state_q   <= S_IDLE;
						end
						CMD_START: begin
							if (n == '0) begin
								running_q <= 1'b0;
								state_q   <= S_OUT;
							end else begin
								pos_q     <= '0;
								off_q     <= '0;
								running_q <= 1'b1;
								state_q   <= S_WAIT;
							end
						end
						CMD_STOP: begin
							running_q <= 1'b0;
							state_q   <= running_q ? S_OUT : S_IDLE;
						end
						default: begin
							if (!running_q) begin
								state_q <= S_IDLE;
							end else if (CFG_W'(pos_q) >= n) begin
								running_q <= 1'b0;
								state_q   <= S_OUT;
							end else begin
								off_q   <= off_q + DUR_W'(1);
								state_q <= S_WAIT;
							end
						end
					endcase
				end
				S_WAIT: begin
					state_q <= S_TCHK;
				end
				S_TCHK: begin
					ch_q <= 1'b0;
					if (off_q >= rd_q.dur) begin
						off_q <= '0;
						if (pos_next >= n) begin
							running_q <= 1'b0;
							state_q   <= S_OUT;
						end else begin
							pos_q   <= pos_next[STEP_W-1:0];
							state_q <= S_WAIT;
						end
					end else begin
						state_q <= S_CH;
					end
				end
				S_CH: begin
					if (ch_en) begin
						state_q <= S_CHW;
					end else if (ch_q) begin
						state_q <= S_OUT;
					end else begin
						ch_q <= 1'b1;
					end
				end
				S_CHW: begin
					if (ip_done) begin
						ch_q    <= 1'b1;
						state_q <= ch_q ? S_OUT : S_CH;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// input latch, result staging and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q  <= s_tdata;
			cmd_q <= s_tuser;
		end
		case (state_q)
			S_DEC: begin
				case (cmd_q)
					CMD_START: begin
						res_q        <= '0;
						res_status_q <= (n == '0) ? ST_NO_STEPS : ST_APPLIED;
					end
					CMD_STOP: begin
						res_status_q <= ST_STOPPED;
						res_q        <= res_data_t'({in_q[95],
							{(OUT_W-STEP_W-1){1'b0}}, pos_q});
					end
					default: begin
						res_status_q <= (CFG_W'(pos_q) >= n) ? ST_DONE : ST_APPLIED;
						res_q        <= res_data_t'({{(OUT_W-STEP_W){1'b0}}, n_last});
					end
				endcase
			end
			S_TCHK: begin
				res_q.step <= (off_q >= rd_q.dur) ? n_last : pos_q;
				if (off_q >= rd_q.dur && pos_next >= n) begin
					res_status_q <= ST_DONE;
				end
			end
			S_CHW: begin
				if (ip_done) begin
					if (ch_q) begin
						res_q.hum_valid <= 1'b1;
						res_q.hum       <= ip_result;
					end else begin
						res_q.temp_valid <= 1'b1;
						res_q.temp       <= ip_result;
					end
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_q        <= res_q;
					out_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = out_status_q;

endmodule

### hdl/rss_checker.sv
// port-level checks of the ramp/soak setpoint sequencer and their binding
module rss_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [rss_pkg::OUT_W-1:0] m_tdata,
	input logic [1:0]                m_tuser
);
	import rss_pkg::*;

	// a pending result word is held until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// one command in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken while another is in work");

	// only applied targets carry channel data
	a_targets: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_APPLIED |-> m_tdata[38:5] == '0)
		else $error("channel data on a non-target word");

	// restore request only on a stop word
	a_restore: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_STOPPED |-> !m_tdata[39])
		else $error("restore request outside a stop word");

	// with the temperature channel disabled, each disabled channel carries a zero target
	a_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[5] |-> m_tdata[21:6] == '0 &&
			(m_tdata[22] || m_tdata[38:23] == '0))
		else $error("nonzero target on a disabled channel");

endmodule

bind ramp_soak_setpoint_sequencer_core rss_checker u_rss_checker (.*);

### dv/testbench.sv
// testbench of the ramp/soak setpoint sequencer core: stream driver, monitor and scoreboard
module testbench;
	import rss_pkg::*;

	// command word fields, packed so that step_index sits in the lowest bits
	typedef struct packed {
		logic                    restore_on_stop;
		logic signed [TGT_W-1:0] hum_finish;
		logic signed [TGT_W-1:0] hum_begin;
		logic                    hum_enable;
		logic signed [TGT_W-1:0] temp_finish;
		logic signed [TGT_W-1:0] temp_begin;
		logic                    temp_enable;
		logic [DUR_W-1:0]        duration_ticks;
		logic [STEP_W-1:0]       step_index;
	} cmd_fields_t;

	// result word fields, current_step in the lowest bits
	typedef struct packed {
		logic                    restore_request;
		logic signed [TGT_W-1:0] target_hum;
		logic                    hum_valid;
		logic signed [TGT_W-1:0] target_temp;
		logic                    temp_valid;
		logic [STEP_W-1:0]       current_step;
	} result_fields_t;

	typedef struct packed {
		logic [1:0]     status;
		result_fields_t word;
	} setpoint_word_t;

	// predictor of the sequencer and queue of the words it still owes
	class setpoint_scoreboard;
		step_t          profile[MAX_STEPS];
		logic [CFG_W-1:0] steps_in_use;
		int             position;
		longint         tick_offset;
		bit             running;
		setpoint_word_t owed_words[$];
		int             errors;
		int             checked;

		function new();
			steps_in_use = '0;
			position = 0;
			tick_offset = 0;
			running = 0;
			errors = 0;
			checked = 0;
		endfunction

		function int pending();
			return owed_words.size();
		endfunction

		function void set_steps(input logic [CFG_W-1:0] v);
			steps_in_use = v;
		endfunction

		function int step_total();
			return (steps_in_use > MAX_STEPS) ? MAX_STEPS : int'(steps_in_use);
		endfunction

		// begin + (finish - begin) * off / (dur - 1), truncated toward zero
		function logic signed [TGT_W-1:0] ramp_value(input logic signed [TGT_W-1:0] b,
				input logic signed [TGT_W-1:0] f, input logic [DUR_W-1:0] dur,
				input longint off);
			longint delta, mag, d, prod, m, w;
			bit     rem;
			if (dur <= 1)
				return f;
			d = longint'(dur) - 1;
			if (off > d)
				off = d;
			delta = longint'(f) - longint'(b);
			mag = (delta < 0) ? -delta : delta;
			prod = mag * off;
			m = prod / d;
			rem = (prod % d) != 0;
			if (delta >= 0) begin
				w = longint'(b) + m;
				if (rem && w < 0)
					w = w + 1;
			end else begin
				w = longint'(b) - m;
				if (rem && w > 0)
					w = w - 1;
			end
			return w[TGT_W-1:0];
		endfunction

		function setpoint_word_t status_word(input logic [1:0] st, input int step);
			setpoint_word_t e;
			e = '0;
			e.status = st;
			e.word.current_step = step[STEP_W-1:0];
			return e;
		endfunction

		// targets of the current step at the current offset
		function setpoint_word_t applied_word();
			setpoint_word_t e;
			step_t          s;
			s = profile[position % MAX_STEPS];
			e = status_word(ST_APPLIED, position);
			if (s.temp_en) begin
				e.word.temp_valid = 1'b1;
				e.word.target_temp = ramp_value(s.temp_from, s.temp_to, s.dur, tick_offset);
			end
			if (s.hum_en) begin
				e.word.hum_valid = 1'b1;
				e.word.target_hum = ramp_value(s.hum_from, s.hum_to, s.dur, tick_offset);
			end
			return e;
		endfunction

		// accepted command word: update state, queue the word it causes
		function void note_command(input logic [1:0] cmd, input cmd_fields_t f);
			int             n;
			setpoint_word_t e;
			n = step_total();
			case (cmd)
				CMD_WRITE: begin
					running = 0;
					profile[f.step_index].dur = (f.duration_ticks == '0) ? DUR_W'(1) :
						f.duration_ticks;
					profile[f.step_index].temp_en = f.temp_enable;
					profile[f.step_index].temp_from = f.temp_begin;
					profile[f.step_index].temp_to = f.temp_finish;
					profile[f.step_index].hum_en = f.hum_enable;
					profile[f.step_index].hum_from = f.hum_begin;
					profile[f.step_index].hum_to = f.hum_finish;
				end
				CMD_START: begin
					if (n == 0) begin
						running = 0;
						owed_words.push_back(status_word(ST_NO_STEPS, 0));
					end else begin
						position = 0;
						tick_offset = 0;
						running = 1;
						owed_words.push_back(applied_word());
					end
				end
				CMD_STOP: begin
					if (running) begin
						running = 0;
						e = status_word(ST_STOPPED, position);
						e.word.restore_request = f.restore_on_stop;
						owed_words.push_back(e);
					end
				end
				default: begin
					if (running) begin
						if (position >= n) begin
							// step count shrunk under a live run
							running = 0;
							owed_words.push_back(status_word(ST_DONE, (n == 0) ? 0 : n - 1));
						end else begin
							tick_offset = tick_offset + 1;
							if (tick_offset >= longint'(profile[position % MAX_STEPS].dur)) begin
								position = position + 1;
								tick_offset = 0;
							end
							if (position >= n) begin
								running = 0;
								owed_words.push_back(status_word(ST_DONE, n - 1));
							end else begin
								owed_words.push_back(applied_word());
							end
						end
					end
				end
			endcase
		endfunction

		task report_mismatch(input string what);
			errors = errors + 1;
			if (errors <= 100)
				$display("mismatch %0d at %0t: %s", errors, $realtime, what);
		endtask

		task check_field(input string name, input longint got, input longint want);
			if (got != want)
				report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		endtask

		// delivered result word against the oldest owed one
		task check_word(input logic [1:0] status, input logic [OUT_W-1:0] data);
			result_fields_t g;
			setpoint_word_t e;
			g = data;
			if (owed_words.size() == 0) begin
				report_mismatch($sformatf("result word with nothing owed, status %0d", status));
			end else begin
				e = owed_words.pop_front();
				checked = checked + 1;
				check_field("status", longint'(status), longint'(e.status));
				check_field("current_step", longint'(g.current_step),
					longint'(e.word.current_step));
				check_field("temp_valid", longint'(g.temp_valid), longint'(e.word.temp_valid));
				check_field("target_temp", longint'(g.target_temp),
					longint'(e.word.target_temp));
				check_field("hum_valid", longint'(g.hum_valid), longint'(e.word.hum_valid));
				check_field("target_hum", longint'(g.target_hum), longint'(e.word.target_hum));
				check_field("restore_request", longint'(g.restore_request),
					longint'(e.word.restore_request));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic [1:0]            m_tuser;
	logic                  cfg_we;
	logic [CFG_W-1:0]      cfg_wdata;

	setpoint_scoreboard    sb;
	bit                    steady;
	bit [MAX_STEPS-1:0]    written;
	int                    sent;
	int                    settings;
	int                    hold_left;

	ramp_soak_setpoint_sequencer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#8000000;
		$display("CHECK FAILED");
		$finish;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 70)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		if (r < 98)
			return int'($urandom_range(4, 12));
		return int'($urandom_range(20, 80));
	endfunction

	// number of table entries written without a hole from entry 0
	function automatic int filled_prefix();
		int k;
		k = 0;
		while (k < MAX_STEPS && written[k])
			k++;
		return k;
	endfunction

	function automatic logic [DUR_W-1:0] pick_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 65)
			return DUR_W'($urandom_range(1, 4));
		if (r < 88)
			return DUR_W'($urandom_range(5, 20));
		return DUR_W'($urandom());
	endfunction

	function automatic cmd_fields_t random_fields();
		cmd_fields_t f;
		f.step_index = STEP_W'($urandom_range(0, MAX_STEPS - 1));
		f.duration_ticks = pick_duration();
		f.temp_enable = 1'($urandom_range(0, 1));
		f.temp_begin = TGT_W'($urandom());
		f.temp_finish = TGT_W'($urandom());
		f.hum_enable = 1'($urandom_range(0, 1));
		f.hum_begin = TGT_W'($urandom());
		f.hum_finish = TGT_W'($urandom());
		f.restore_on_stop = 1'($urandom_range(0, 1));
		return f;
	endfunction

	function automatic cmd_fields_t step_fields(input int idx, input int dur,
			input int te, input int tb, input int tf, input int he, input int hb,
			input int hf);
		cmd_fields_t f;
		f = random_fields();
		f.step_index = STEP_W'(idx);
		f.duration_ticks = DUR_W'(dur);
		f.temp_enable = te[0];
		f.temp_begin = TGT_W'(tb);
		f.temp_finish = TGT_W'(tf);
		f.hum_enable = he[0];
		f.hum_begin = TGT_W'(hb);
		f.hum_finish = TGT_W'(hf);
		return f;
	endfunction

	// offer one command word and hold it until taken
	task automatic send(input logic [1:0] cmd, input cmd_fields_t f);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= f;
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, f);
		if (cmd == CMD_WRITE)
			written[f.step_index] = 1'b1;
		sent++;
	endtask

	task automatic send_other(input logic [1:0] cmd);
		send(cmd, random_fields());
	endtask

	// step count write once the block has drained
	task automatic set_steps(input logic [CFG_W-1:0] v);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_steps(v);
		settings++;
	endtask

	// result side: check delivered words, stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tuser, m_tdata);
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			hold_left = pick_gap();
			m_tready <= (hold_left == 0);
		end
	end

	// stimulus
	initial begin
		cmd_fields_t f;
		int          r;
		int          write_pct;
		int          p;
		logic [CFG_W-1:0] v;

		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_WRITE;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		steady = 0;
		written = '0;
		sent = 0;
		settings = 0;
		hold_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table start, idle stop and tick, extremes, rounding near zero
		set_steps(CFG_W'(0));
		send_other(CMD_START);
		send_other(CMD_TICK);
		send_other(CMD_STOP);
		send(CMD_WRITE, step_fields(0, 0, 1, -32768, 32767, 1, 32767, -32768));
		send(CMD_WRITE, step_fields(1, 5, 1, 100, -7, 0, 1234, -1234));
		send(CMD_WRITE, step_fields(2, 24'hFFFFFF, 1, -5, 3, 1, 3, -5));
		send(CMD_WRITE, step_fields(31, 3, 0, 7, 9, 1, -1, 1));
		send(CMD_WRITE, step_fields(3, 2, 0, 0, 0, 0, 0, 0));
		set_steps(CFG_W'(3));
		send_other(CMD_START);
		repeat (7) send_other(CMD_TICK);
		f = random_fields();
		f.restore_on_stop = 1'b1;
		send(CMD_STOP, f);
		send_other(CMD_START);
		send_other(CMD_START);
		// write under a live run ends it without a word
		send(CMD_WRITE, step_fields(3, 1, 1, 50, 60, 1, -50, -60));
		send_other(CMD_TICK);
		send_other(CMD_START);
		send_other(CMD_TICK);
		// shrink the step count under a live run
		set_steps(CFG_W'(1));
		send_other(CMD_TICK);

		// random phases
		for (int phase = 0; phase < 12; phase++) begin
			p = filled_prefix();
			if (phase < 3) begin
				v = CFG_W'(p);
			end else begin
				case (phase % 5)
					0: v = CFG_W'(p);
					1: v = (p >= 1) ? CFG_W'(1) : CFG_W'(0);
					2: v = '0;
					3: v = CFG_W'($urandom_range(0, p));
					default: v = (p == MAX_STEPS) ? 6'd63 : CFG_W'(p);
				endcase
			end
			set_steps(v);
			steady = (phase % 4 == 1);
			write_pct = (phase < 3) ? 30 : int'($urandom_range(2, 12));
			for (int i = 0; i < 85; i++) begin
				r = $urandom_range(0, 99);
				if (r < write_pct) begin
					f = random_fields();
					p = filled_prefix();
					if (p < MAX_STEPS && $urandom_range(0, 1))
						f.step_index = STEP_W'(p);
					send(CMD_WRITE, f);
				end else if (r < write_pct + 8) begin
					send_other(CMD_START);
				end else if (r < write_pct + 13) begin
					send_other(CMD_STOP);
				end else begin
					send_other(CMD_TICK);
				end
				// the step count may not reach past the written entries
				if (sb.steps_in_use > filled_prefix() && filled_prefix() < MAX_STEPS)
					$display("internal: step count beyond written entries");
			end
		end

		// drain
		steady = 0;
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d result words never arrived", sb.pending()));
		$display("covered %0d commands and %0d result words over %0d step count settings",
			sent, sb.checked, settings);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
hdl/rss_pkg.sv
hdl/rss_interp.sv
hdl/ramp_soak_setpoint_sequencer_core.sv
hdl/rss_checker.sv
dv/testbench.sv
